FILE: rtl/whd_pkg.sv
// ----------------------------------------------------------------------------
// whd_pkg
// Shared constants for the weighted 3x3 half-size downsampler.
// ----------------------------------------------------------------------------
package whd_pkg;

   localparam int CFG_BITS     = 13;
   localparam int ROW_BITS     = 12;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int DIV_BITS     = 9;
   localparam int WSUM_BITS    = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

   // register index, taken from paddr[2]
   localparam logic REG_IN_WIDTH  = 1'b0;
   localparam logic REG_IN_HEIGHT = 1'b1;

   // sums of the weights left in one axis: centre, centre+one side, all three
   localparam logic [WSUM_BITS-1:0] WSUM_C   = 5'd10;
   localparam logic [WSUM_BITS-1:0] WSUM_CS  = 5'd13;
   localparam logic [WSUM_BITS-1:0] WSUM_CSS = 5'd16;

   // normaliser weights that can occur (products of the sums above)
   localparam logic [DIV_BITS-1:0] WT_100 = 9'd100;
   localparam logic [DIV_BITS-1:0] WT_130 = 9'd130;
   localparam logic [DIV_BITS-1:0] WT_160 = 9'd160;
   localparam logic [DIV_BITS-1:0] WT_169 = 9'd169;
   localparam logic [DIV_BITS-1:0] WT_208 = 9'd208;
   localparam logic [DIV_BITS-1:0] WT_256 = 9'd256;

endpackage

FILE: rtl/whd_recip_div.sv
// ----------------------------------------------------------------------------
// whd_recip_div
// Divides the rounded window sum by its weight total (one of six constants)
// through a reciprocal multiply and a single correction step. Four stages,
// each with its own valid bit, the last one being the output register.
// ----------------------------------------------------------------------------
module whd_recip_div #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [SAMPLE_BITS+7:0]             in_num,
   input  logic [whd_pkg::DIV_BITS-1:0]       in_div,
   input  logic                               in_last,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [SAMPLE_BITS-1:0]             out_quot,
   output logic                               out_last
);

   localparam int NW = SAMPLE_BITS + 8;
   localparam int RW = NW - 6;
   localparam int DW = whd_pkg::DIV_BITS;

   localparam logic [RW-1:0] RECIP_100 = RW'((64'd1 << NW) / 64'd100);
   localparam logic [RW-1:0] RECIP_130 = RW'((64'd1 << NW) / 64'd130);
   localparam logic [RW-1:0] RECIP_160 = RW'((64'd1 << NW) / 64'd160);
   localparam logic [RW-1:0] RECIP_169 = RW'((64'd1 << NW) / 64'd169);
   localparam logic [RW-1:0] RECIP_208 = RW'((64'd1 << NW) / 64'd208);
   localparam logic [RW-1:0] RECIP_256 = RW'((64'd1 << NW) / 64'd256);

   function automatic logic [RW-1:0] recip_of(input logic [DW-1:0] d);
      logic [RW-1:0] r;
      case (d)
         whd_pkg::WT_100: r = RECIP_100;
         whd_pkg::WT_130: r = RECIP_130;
         whd_pkg::WT_160: r = RECIP_160;
         whd_pkg::WT_169: r = RECIP_169;
         whd_pkg::WT_208: r = RECIP_208;
         default:         r = RECIP_256;
      endcase
      return r;
   endfunction

   // stage 0: operands
   logic          s0_valid_ff, s0_valid_in;
   logic [NW-1:0] s0_num_ff;
   logic [DW-1:0] s0_div_ff;
   logic          s0_last_ff;
   // stage 1: num * reciprocal
   logic             s1_valid_ff, s1_valid_in;
   logic [NW+RW-1:0] s1_prod_ff;
   logic [NW-1:0]    s1_num_ff;
   logic [DW-1:0]    s1_div_ff;
   logic             s1_last_ff;
   // stage 2: estimate * divisor
   logic             s2_valid_ff, s2_valid_in;
   logic [RW-1:0]    s2_quot_ff;
   logic [RW+DW-1:0] s2_back_ff;
   logic [NW-1:0]    s2_num_ff;
   logic [DW-1:0]    s2_div_ff;
   logic             s2_last_ff;
   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_quot_ff;
   logic                   out_last_ff;

   logic          go0, go1, go2, go3;
   logic [RW-1:0] est;
   logic [NW-1:0] rem;
   logic [RW-1:0] quot_fix;

   assign go3 = !out_valid_ff || out_ready;
   assign go2 = !s2_valid_ff || go3;
   assign go1 = !s1_valid_ff || go2;
   assign go0 = !s0_valid_ff || go1;
   assign in_ready = go0;

   assign s0_valid_in  = go0 ? in_valid : s0_valid_ff;
   assign s1_valid_in  = go1 ? s0_valid_ff : s1_valid_ff;
   assign s2_valid_in  = go2 ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = go3 ? s2_valid_ff : out_valid_ff;

   assign est      = s1_prod_ff[NW+RW-1:NW];
   assign rem      = s2_num_ff - s2_back_ff[NW-1:0];
   assign quot_fix = (rem >= NW'(s2_div_ff)) ? s2_quot_ff + RW'(1) : s2_quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go0) begin
         s0_num_ff  <= in_num;
         s0_div_ff  <= in_div;
         s0_last_ff <= in_last;
      end
      if (go1) begin
         s1_prod_ff <= (NW+RW)'(s0_num_ff) * (NW+RW)'(recip_of(s0_div_ff));
         s1_num_ff  <= s0_num_ff;
         s1_div_ff  <= s0_div_ff;
         s1_last_ff <= s0_last_ff;
      end
      if (go2) begin
         s2_quot_ff <= est;
         s2_back_ff <= (RW+DW)'(est) * (RW+DW)'(s1_div_ff);
         s2_num_ff  <= s1_num_ff;
         s2_div_ff  <= s1_div_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (go3) begin
         out_quot_ff <= quot_fix[SAMPLE_BITS-1:0];
         out_last_ff <= s2_last_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_quot_ff;
   assign out_last  = out_last_ff;

endmodule

FILE: rtl/weighted_half_downsample_3x3_core.sv
// ----------------------------------------------------------------------------
// weighted_half_downsample_3x3_core
// Halves one image plane in each axis with a separable 3,10,3 window,
// normalised by the weights that fall inside the image.
// ----------------------------------------------------------------------------
// Takes one sample per clock in raster order and keeps that rate for as long
// as the result side keeps up; a result passes through the stage B and C
// registers and the divider stages after the sample completing its window is
// taken. The two line stores are single synchronous RAMs of MAX_WIDTH entries,
// read when a sample is taken and written back as that sample moves on out of
// stage B, with a bypass for a width of one column.
// After reset the line stores are swept to zero, one entry per clock, so no
// sample is taken until all MAX_WIDTH entries are cleared; register writes are
// accepted throughout.
module weighted_half_downsample_3x3_core #(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   // rsp_tdata: out_sample; rsp_tlast: frame_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [whd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [whd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [whd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int CW  = (XW + 1 > whd_pkg::CFG_BITS) ? XW + 1 : whd_pkg::CFG_BITS;
   localparam int SB  = SAMPLE_BITS;
   localparam int VW  = SAMPLE_BITS + 4;
   localparam int NW  = SAMPLE_BITS + 8;
   localparam int HB  = whd_pkg::CFG_BITS;
   localparam int YW  = whd_pkg::ROW_BITS;
   localparam int WB  = whd_pkg::WSUM_BITS;
   localparam int DW  = whd_pkg::DIV_BITS;
   localparam int PDW = whd_pkg::CSR_DATA_W;

   function automatic logic [NW-1:0] times10(input logic [NW-1:0] v);
      return (v << 3) + (v << 1);
   endfunction

   function automatic logic [NW-1:0] times3(input logic [NW-1:0] v);
      return (v << 1) + v;
   endfunction

   // configuration
   logic [HB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic          csr_wr;

   // counters and line-store sweep
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          clr_busy_ff, clr_busy_in;
   logic [XW-1:0] clr_addr_ff, clr_addr_in;

   // line stores
   logic [SB-1:0] upper_mem [MAX_WIDTH];
   logic [SB-1:0] middle_mem [MAX_WIDTH];
   logic [SB-1:0] up_q_ff, mid_q_ff;
   logic          mem_we;
   logic [XW-1:0] mem_wa;
   logic [SB-1:0] mem_wu, mem_wm;

   // stage B: line data back, vertical sum
   logic          b_valid_ff, b_valid_in;
   logic [XW-1:0] b_addr_ff;
   logic [SB-1:0] b_cur_ff;
   logic          b_y_odd_ff, b_y_ge1_ff, b_y_ge2_ff;
   logic          b_x_odd_ff, b_x_ge1_ff, b_x_ge2_ff;
   logic          b_emit_ff, b_last_ff;
   logic          b_hit_ff;
   logic [SB-1:0] b_fwd_up_ff, b_fwd_mid_ff;

   // previous two vertical sums of this row
   logic [VW-1:0] prev0_ff, prev1_ff;

   // stage C: horizontal sum
   logic          c_valid_ff, c_valid_in;
   logic [VW-1:0] c_vs_ff, c_p0_ff, c_p1_ff;
   logic [WB-1:0] c_wv_ff;
   logic          c_x_odd_ff, c_x_ge1_ff, c_x_ge2_ff, c_last_ff;

   logic [CW-1:0] w_ext, w_eff;
   logic [HB-1:0] h_eff;
   logic          last_col, last_row, emit;
   logic          accept, b_go, b_leave, c_go;
   logic [SB-1:0] up_eff, mid_eff;
   logic [NW-1:0] vs_sum, hs_sum, num;
   logic [WB-1:0] wv, wh;
   logic [2*WB-1:0] wt_prod;
   logic [DW-1:0] wt;
   logic          div_ready;
   logic [SB-1:0] div_quot;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == whd_pkg::REG_IN_WIDTH) begin
            width_in = csr_pwdata[HB-1:0];
         end else begin
            height_in = csr_pwdata[HB-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == whd_pkg::REG_IN_HEIGHT) ?
                       PDW'(height_ff) : PDW'(width_ff);

   // ---------------- geometry ----------------
   assign w_ext = CW'(width_ff);

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (height_ff == '0) begin
         h_eff = HB'(1);
      end else if (height_ff > HB'(whd_pkg::HEIGHT_LIMIT)) begin
         h_eff = HB'(whd_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign last_col = (CW'(col_ff) + CW'(1)) >= w_eff;
   assign last_row = (HB'(row_ff) + HB'(1)) >= h_eff;
   assign emit     = (row_ff[0] || last_row) && (col_ff[0] || last_col);

   // ---------------- flow control ----------------
   assign c_go       = !c_valid_ff || div_ready;
   assign b_go       = !b_valid_ff || !b_emit_ff || c_go;
   assign b_leave    = b_valid_ff && b_go;
   assign req_tready = !clr_busy_ff && (!b_valid_ff || b_go);
   assign accept     = req_tvalid && req_tready;

   assign b_valid_in = (!b_valid_ff || b_go) ? accept : b_valid_ff;
   assign c_valid_in = c_go ? (b_valid_ff && b_emit_ff) : c_valid_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + YW'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != XW'(MAX_WIDTH - 1));
   assign clr_addr_in = clr_addr_ff + XW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= whd_pkg::WIDTH_RESET;
         height_ff   <= whd_pkg::HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         prev0_ff    <= '0;
         prev1_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         b_valid_ff  <= b_valid_in;
         c_valid_ff  <= c_valid_in;
         if (b_leave) begin
            prev0_ff <= vs_sum[VW-1:0];
            prev1_ff <= prev0_ff;
         end
      end
   end

   // ---------------- line stores ----------------
   assign mem_we = clr_busy_ff || b_leave;
   assign mem_wa = clr_busy_ff ? clr_addr_ff : b_addr_ff;
   assign mem_wu = clr_busy_ff ? '0 : mid_eff;
   assign mem_wm = clr_busy_ff ? '0 : b_cur_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[mem_wa]  <= mem_wu;
         middle_mem[mem_wa] <= mem_wm;
      end
      if (accept) begin
         up_q_ff  <= upper_mem[col_ff];
         mid_q_ff <= middle_mem[col_ff];
      end
   end

   // ---------------- stage B load ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff    <= col_ff;
         b_cur_ff     <= req_tdata[SB-1:0];
         b_y_odd_ff   <= row_ff[0];
         b_y_ge1_ff   <= row_ff != '0;
         b_y_ge2_ff   <= row_ff > YW'(1);
         b_x_odd_ff   <= col_ff[0];
         b_x_ge1_ff   <= col_ff != '0;
         b_x_ge2_ff   <= col_ff > XW'(1);
         b_emit_ff    <= emit;
         b_last_ff    <= last_row && last_col;
         // same entry written back on this edge: take it from the bypass
         b_hit_ff     <= b_leave && (b_addr_ff == col_ff);
         b_fwd_up_ff  <= mid_eff;
         b_fwd_mid_ff <= b_cur_ff;
      end
   end

   // ---------------- stage B: vertical sum ----------------
   assign up_eff  = b_hit_ff ? b_fwd_up_ff : up_q_ff;
   assign mid_eff = b_hit_ff ? b_fwd_mid_ff : mid_q_ff;

   always_comb begin
      if (b_y_odd_ff) begin
         vs_sum = times10(NW'(mid_eff)) + times3(NW'(b_cur_ff));
         wv     = whd_pkg::WSUM_CS;
         if (b_y_ge2_ff) begin
            vs_sum = vs_sum + times3(NW'(up_eff));
            wv     = whd_pkg::WSUM_CSS;
         end
      end else begin
         vs_sum = times10(NW'(b_cur_ff));
         wv     = whd_pkg::WSUM_C;
         if (b_y_ge1_ff) begin
            vs_sum = vs_sum + times3(NW'(mid_eff));
            wv     = whd_pkg::WSUM_CS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_go) begin
         c_vs_ff    <= vs_sum[VW-1:0];
         c_p0_ff    <= prev0_ff;
         c_p1_ff    <= prev1_ff;
         c_wv_ff    <= wv;
         c_x_odd_ff <= b_x_odd_ff;
         c_x_ge1_ff <= b_x_ge1_ff;
         c_x_ge2_ff <= b_x_ge2_ff;
         c_last_ff  <= b_last_ff;
      end
   end

   // ---------------- stage C: horizontal sum and rounding ----------------
   always_comb begin
      if (c_x_odd_ff) begin
         hs_sum = times10(NW'(c_p0_ff)) + times3(NW'(c_vs_ff));
         wh     = whd_pkg::WSUM_CS;
         if (c_x_ge2_ff) begin
            hs_sum = hs_sum + times3(NW'(c_p1_ff));
            wh     = whd_pkg::WSUM_CSS;
         end
      end else begin
         hs_sum = times10(NW'(c_vs_ff));
         wh     = whd_pkg::WSUM_C;
         if (c_x_ge1_ff) begin
            hs_sum = hs_sum + times3(NW'(c_p0_ff));
            wh     = whd_pkg::WSUM_CS;
         end
      end
   end

   assign wt_prod = (2*WB)'(c_wv_ff) * (2*WB)'(wh);
   assign wt      = wt_prod[DW-1:0];
   assign num     = hs_sum + NW'(wt[DW-1:1]);

   whd_recip_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_ready  (div_ready),
      .in_num    (num),
      .in_div    (wt),
      .in_last   (c_last_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_quot  (div_quot),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = TDW'(div_quot);

endmodule

FILE: tb/sv/weighted_half_downsample_3x3_core_tb.sv
// ----------------------------------------------------------------------------
// weighted_half_downsample_3x3_core_tb
// Streams image planes of many sizes through the 3x3 half-size downsampler
// and checks every reduced sample and its frame-end flag against an
// in-bench model of the weighted, normalised window. Register writes happen
// only with the block idle, some of them part-way through a frame. Sender
// gaps and receiver stalls are mixed in over several phases.
// ----------------------------------------------------------------------------
module weighted_half_downsample_3x3_core_tb;

   localparam int MAX_W  = 4096;
   localparam int SETTLE = 16;
   localparam int CFG_W  = whd_pkg::CFG_BITS;

   typedef struct packed {
      logic [15:0] pix;
      logic        frame_end;
   } reduced_px_type;

   class decimate_checker_type;
      logic [CFG_W-1:0]    width_reg;
      logic [CFG_W-1:0]    height_reg;
      logic [15:0]         upper_row [MAX_W];
      logic [15:0]         middle_row [MAX_W];
      int unsigned         col;
      int unsigned         row;
      int unsigned         col_sum [2];
      reduced_px_type      pending_px [$];
      int                  errors;
      int                  samples;
      int                  results;
      int                  frames;

      function new();
         width_reg  = whd_pkg::WIDTH_RESET;
         height_reg = whd_pkg::HEIGHT_RESET;
         foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         col        = 0;
         row        = 0;
         col_sum[0] = 0;
         col_sum[1] = 0;
         errors     = 0;
         samples    = 0;
         results    = 0;
         frames     = 0;
      endfunction

      function void report(string msg);
         errors++;
         $display("%0t: %s", $time, msg);
      endfunction

      function int unsigned plane_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function int unsigned plane_height();
         if (height_reg == 0) return 1;
         if (height_reg > whd_pkg::HEIGHT_LIMIT) return whd_pkg::HEIGHT_LIMIT;
         return height_reg;
      endfunction

      function void write_reg(logic idx, logic [CFG_W-1:0] val);
         if (idx == whd_pkg::REG_IN_WIDTH) begin
            width_reg = val;
         end else begin
            height_reg = val;
         end
      endfunction

      function int pending();
         return pending_px.size();
      endfunction

      // words still to come before the counters return to the frame origin
      function int unsigned frame_left();
         int unsigned w;
         int unsigned h;
         int unsigned this_row;
         int unsigned rows_after;
         w          = plane_width();
         h          = plane_height();
         this_row   = (col >= w - 1) ? 1 : (w - col);
         rows_after = (row >= h - 1) ? 0 : (h - 1 - row);
         return this_row + rows_after * w;
      endfunction

      function void take_sample(logic [15:0] px);
         int unsigned w;
         int unsigned h;
         int unsigned xi;
         int unsigned cur;
         int unsigned up;
         int unsigned mid;
         int unsigned vs;
         int unsigned wv;
         int unsigned hs;
         int unsigned wh;
         int unsigned wt;
         bit          last_col;
         bit          last_row;
         reduced_px_type exp_px;
         w        = plane_width();
         h        = plane_height();
         xi       = (col < MAX_W) ? col : MAX_W - 1;
         cur      = px;
         up       = upper_row[xi];
         mid      = middle_row[xi];
         last_col = (col >= w - 1);
         last_row = (row >= h - 1);
         samples++;
         // vertical pass: taps above row 0 dropped
         if (row % 2 == 1) begin
            vs = 10 * mid + 3 * cur;
            wv = 13;
            if (row >= 2) begin
               vs += 3 * up;
               wv = 16;
            end
         end else begin
            vs = 10 * cur;
            wv = 10;
            if (row >= 1) begin
               vs += 3 * mid;
               wv = 13;
            end
         end
         if ((row % 2 == 1 || last_row) && (col % 2 == 1 || last_col)) begin
            if (col % 2 == 1) begin
               hs = 10 * col_sum[0] + 3 * vs;
               wh = 13;
               if (col >= 2) begin
                  hs += 3 * col_sum[1];
                  wh = 16;
               end
            end else begin
               hs = 10 * vs;
               wh = 10;
               if (col >= 1) begin
                  hs += 3 * col_sum[0];
                  wh = 13;
               end
            end
            wt               = wv * wh;
            exp_px.pix       = 16'((hs + wt / 2) / wt);
            exp_px.frame_end = last_row && last_col;
            pending_px.push_back(exp_px);
         end
         col_sum[1]     = col_sum[0];
         col_sum[0]     = vs;
         upper_row[xi]  = 16'(mid);
         middle_row[xi] = px;
         if (last_col) begin
            col = 0;
            row = last_row ? 0 : row + 1;
         end else begin
            col++;
         end
      endfunction

      function void match_result(logic [15:0] pix, logic frame_end);
         reduced_px_type exp_px;
         results++;
         if (frame_end) frames++;
         if (pending_px.size() == 0) begin
            report($sformatf("unexpected word: out_sample %h frame_end %b", pix, frame_end));
            return;
         end
         exp_px = pending_px.pop_front();
         if (pix !== exp_px.pix) begin
            report($sformatf("out_sample expected %h, got %h", exp_px.pix, pix));
         end
         if (frame_end !== exp_px.frame_end) begin
            report($sformatf("frame_end expected %b, got %b", exp_px.frame_end, frame_end));
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset       = 1'b1;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   logic [15:0]                        req_tdata   = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   logic [15:0]                        rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [whd_pkg::CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [whd_pkg::CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [whd_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                               csr_pready;

   int                    req_gap_pct   = 0;
   int                    rsp_stall_pct = 0;
   decimate_checker_type  sb;

   weighted_half_downsample_3x3_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.take_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.match_result(rsp_tdata, rsp_tlast);
      end
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(15);
      if (r == 0) return '0;
      if (r < 12) return CFG_W'($urandom_range(8, 1));
      return CFG_W'($urandom_range(24, 9));
   endfunction

   // valid stays high from one word to the next unless a gap is drawn
   task automatic push_sample(input logic [15:0] px);
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) push_sample(pick_sample());
   endtask

   // sender quiet, all results in, pipeline given time to finish line writes
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic idx, input logic [CFG_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {19'($urandom), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (wr) begin
         sb.write_reg(idx, val);
      end else if (csr_prdata[CFG_W-1:0] !== val) begin
         sb.report($sformatf("register %0d read expected %h, got %h",
                             idx, val, csr_prdata[CFG_W-1:0]));
      end
   endtask

   task automatic reconfigure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      settle();
      csr_access(1'b1, whd_pkg::REG_IN_WIDTH, w);
      csr_access(1'b1, whd_pkg::REG_IN_HEIGHT, h);
      csr_access(1'b0, whd_pkg::REG_IN_WIDTH, w);
      csr_access(1'b0, whd_pkg::REG_IN_HEIGHT, h);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [15:0] corner_px [9];
      int          gap_plan [4];
      int          stall_plan [4];
      int          p;
      int unsigned sent;
      int unsigned n;
      int unsigned cut;
      corner_px  = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFE,
                     16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000};
      gap_plan   = '{0, 48, 0, 8};
      stall_plan = '{0, 0, 48, 8};
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      reconfigure(13'd3, 13'd3);
      foreach (corner_px[i]) push_sample(corner_px[i]);
      // zero width and height act as one
      reconfigure(13'd0, 13'd0);
      push_sample(16'hFFFF);
      push_sample(16'h0000);
      reconfigure(13'd2, 13'd1);
      push_sample(16'hFFFF);
      push_sample(16'h1234);
      // shrink both dimensions behind the counters part-way through a frame
      reconfigure(13'd4, 13'd5);
      send_random(6);
      reconfigure(13'd2, 13'd2);
      send_random(sb.frame_left());

      for (p = 0; p < 4; p++) begin
         req_gap_pct   = gap_plan[p];
         rsp_stall_pct = stall_plan[p];
         sent = 0;
         while (sent < 340) begin
            reconfigure(pick_size(), pick_size());
            n = sb.frame_left();
            if (n > 1 && $urandom_range(5) == 0) begin
               cut = $urandom_range(n - 1, 1);
               send_random(cut);
               sent += cut;
               if ($urandom_range(1) == 1) begin
                  reconfigure(pick_size(), pick_size());
               end else begin
                  settle();
               end
               n = sb.frame_left();
            end
            send_random(n);
            sent += n;
         end
      end

      // registers above the limits, frame then cut short by a smaller size
      reconfigure(13'h1FFF, 13'h1FFF);
      send_random(30);
      reconfigure(13'd4, 13'd2);
      send_random(sb.frame_left());
      reconfigure(13'd1, 13'h1FFF);
      send_random(20);
      reconfigure(13'd1, 13'd3);
      send_random(sb.frame_left());
      settle();

      $display("Fed %0d samples and checked %0d reduced words over %0d reduced frames,",
               sb.samples, sb.results, sb.frames);
      $display("planes from one sample up to 24 by 24, out-of-range and mid-frame sizes, four idle mixes.");
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/whd_pkg.sv
rtl/whd_recip_div.sv
rtl/weighted_half_downsample_3x3_core.sv
tb/sv/weighted_half_downsample_3x3_core_tb.sv
